### rtl/clig_pkg.sv
`default_nettype none
package clig_pkg;

    localparam int PAT_MAX     = 16;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_IDX_W   = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int CNT_W       = 24;
    localparam int LEN_W       = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [7:0]       NEWLINE_BYTE = 8'd10;
    localparam logic [7:0]       COMMENT_BYTE = 8'd42;
    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2,
        CFG_LIMIT    = 2'd3
    } t_cfg_idx;

    // pattern settings seen by the matcher
    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [LEN_W-1:0]       eff_len;
    } t_match_cfg;

    // one counted line end
    typedef struct packed {
        logic valid;
        logic hit;
    } t_line_end;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'd65 && c <= 8'd90) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/clig_char_if.sv
`default_nettype none
interface clig_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface
`default_nettype wire

### rtl/clig_match_if.sv
`default_nettype none
interface clig_match_if;
    logic        valid;
    logic        ready;
    logic [23:0] line_number;
    logic        limit_reached;

    modport source (output valid, output line_number, output limit_reached, input ready);
    modport sink   (input valid, input line_number, input limit_reached, output ready);
endinterface
`default_nettype wire

### rtl/clig_front.sv
`default_nettype none
module clig_front
    import clig_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_match_cfg i_cfg,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_queue_full,
    output logic            o_ready,
    output t_line_end       o_push
);

    logic [PAT_MAX-1:0] r_partial, n_partial;
    logic               r_at_start, n_at_start;
    logic               r_skip, n_skip;
    logic               r_matched, n_matched;
    logic [PAT_MAX-1:0] eq_vec;
    logic [PAT_MAX-1:0] shifted;
    logic [PAT_IDX_W-1:0] len_idx;
    logic [7:0]         fc;
    logic               accept;
    logic               skip_now;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign fc      = fold_case(i_char_byte);
    assign len_idx = PAT_IDX_W'(i_cfg.eff_len - LEN_W'(1));

    // compare every pattern position with the folded byte at once
    always_comb begin
        for (int k = 0; k < PAT_MAX; k++) begin
            eq_vec[k] = (fold_case(8'(i_cfg.pattern >> (8 * k))) == fc);
        end
    end

    assign shifted  = PAT_MAX'({r_partial, 1'b1});
    assign skip_now = r_at_start ? (i_char_byte == COMMENT_BYTE) : r_skip;

    always_comb begin
        n_partial  = r_partial;
        n_at_start = r_at_start;
        n_skip     = r_skip;
        n_matched  = r_matched;
        o_push     = '0;
        if (accept) begin
            if (i_char_byte == NEWLINE_BYTE) begin
                o_push.valid = !r_at_start && !r_skip;
                o_push.hit   = r_matched || (i_cfg.eff_len == '0);
                n_partial    = '0;
                n_at_start   = 1'b1;
                n_skip       = 1'b0;
                n_matched    = 1'b0;
            end else begin
                n_at_start = 1'b0;
                n_skip     = skip_now;
                if (!skip_now) begin
                    n_partial = shifted & eq_vec;
                    if (i_cfg.eff_len != '0 && n_partial[len_idx]) begin
                        n_matched = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_at_start <= 1'b1;
            r_skip     <= 1'b0;
            r_matched  <= 1'b0;
        end else begin
            r_partial  <= n_partial;
            r_at_start <= n_at_start;
            r_skip     <= n_skip;
            r_matched  <= n_matched;
        end
    end

endmodule
`default_nettype wire

### rtl/clig_queue.sv
`default_nettype none
module clig_queue
    import clig_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_line_end i_push,
    input  wire logic      i_pop,
    output logic           o_full,
    output t_line_end      o_head
);

    logic [1:0] r_count, n_count;
    logic       r_wr, r_rd;
    logic       r_mem [2];

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.hit   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !(i_pop && o_head.valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push.valid && i_pop && o_head.valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wr <= !r_wr;
            end
            if (i_pop && o_head.valid) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.hit;
        end
    end

endmodule
`default_nettype wire

### rtl/clig_back.sv
`default_nettype none
module clig_back
    import clig_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_match_limit,
    input  wire t_line_end        i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [CNT_W-1:0]      o_line_number,
    output logic                  o_limit_reached
);

    logic [CNT_W-1:0] r_line_cnt, n_line_cnt;
    logic [CNT_W-1:0] r_match_cnt, n_match_cnt;
    logic             r_valid, n_valid;
    logic [CNT_W-1:0] r_line_number;
    logic             r_limit;
    logic             report;

    assign o_pop   = i_head.valid && (!r_valid || i_ready);
    assign n_line_cnt  = (r_line_cnt != CNT_MAX) ? r_line_cnt + CNT_W'(1) : r_line_cnt;
    assign n_match_cnt = r_match_cnt + CNT_W'(1);
    assign report  = o_pop && i_head.hit && (r_match_cnt < i_match_limit);

    always_comb begin
        n_valid = r_valid;
        if (report) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_cnt  <= '0;
            r_match_cnt <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (o_pop) begin
                r_line_cnt <= n_line_cnt;
            end
            if (report) begin
                r_match_cnt <= n_match_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (report) begin
            r_line_number <= n_line_cnt;
            r_limit       <= (n_match_cnt == i_match_limit);
        end
    end

    assign o_valid         = r_valid;
    assign o_line_number   = r_line_number;
    assign o_limit_reached = r_limit;

endmodule
`default_nettype wire

### rtl/case_insensitive_line_grep_unit.sv
// channel   dir  payload                         request accepted when
// i_char    in   char_byte[7:0]                  valid && ready
// o_match   out  line_number[23:0], limit_reached valid && ready
// i_cfg_*   in   idx[1:0], data[63:0]            i_cfg_we high
//
// one byte per cycle while ready; all 16 pattern positions compare at once
// a line result is registered in the line-end queue, then in the output register
// a two-entry line-end queue lets the byte side run while the result is stalled
// synchronous active-low reset; ready drops only when that queue is full
`default_nettype none
module case_insensitive_line_grep_unit
    import clig_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    clig_char_if.sink                  i_char,
    clig_match_if.source               o_match,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [63:0]      r_pat_low;
    logic [63:0]      r_pat_high;
    logic [LEN_W-1:0] r_pat_len;
    logic [CNT_W-1:0] r_limit;
    t_match_cfg       match_cfg;
    t_line_end        push;
    t_line_end        head;
    logic             queue_full;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
            r_limit    <= CNT_W'(15);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PAT_LOW:  r_pat_low  <= i_cfg_data[63:0];
                CFG_PAT_HIGH: r_pat_high <= i_cfg_data[63:0];
                CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[LEN_W-1:0];
                CFG_LIMIT:    r_limit    <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // lengths past the matcher width saturate
    assign match_cfg.pattern = {r_pat_high, r_pat_low};
    assign match_cfg.eff_len = (int'(r_pat_len) > PAT_MAX) ? LEN_W'(PAT_MAX) : r_pat_len;

    clig_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (match_cfg),
        .i_valid      (i_char.valid),
        .i_char_byte  (i_char.char_byte),
        .i_queue_full (queue_full),
        .o_ready      (i_char.ready),
        .o_push       (push)
    );

    clig_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    clig_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_match_limit   (r_limit),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_match.valid),
        .i_ready         (o_match.ready),
        .o_line_number   (o_match.line_number),
        .o_limit_reached (o_match.limit_reached)
    );

endmodule
`default_nettype wire
